@@ sv/mrb2_pkg.sv @@
`default_nettype none

package mrb2_pkg;

  // candidate width and verdict width
  localparam int CW = 11;
  localparam int VW = 2;
  // counter width, holds 0..CW
  localparam int SW = $clog2(CW + 1);

  localparam int CANDIDATE_LIMIT_DEF = 2047;

  localparam logic [VW-1:0] VERDICT_PRIME     = 2'd0;
  localparam logic [VW-1:0] VERDICT_COMPOSITE = 2'd1;
  localparam logic [VW-1:0] VERDICT_REJECTED  = 2'd2;

  // 2*v mod m, v < m
  function automatic logic [CW-1:0] mod_dbl(input logic [CW-1:0] v,
                                            input logic [CW-1:0] m);
    logic [CW:0] t;
    t = {v, 1'b0};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[CW-1:0];
  endfunction

  // (u + v) mod m, u < m, v < m
  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] u,
                                            input logic [CW-1:0] v,
                                            input logic [CW-1:0] m);
    logic [CW:0] t;
    t = {1'b0, u} + {1'b0, v};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[CW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/miller_rabin_base2_prime_test.sv @@
`default_nettype none

// Miller-Rabin primality test, witness 2, for 11-bit candidates.
// Command port: a word on candidate is taken at a rising edge where start
// is high and busy is low. Busy stays high until the verdict is issued.
// Result: verdict is valid for exactly one cycle while done is high
// (0 prime, 1 composite, 2 rejected). The receiver cannot stall it.
// Rejected words (even, below 3, or at/above CANDIDATE_LIMIT) are answered
// in the cycle after acceptance and never raise busy.
// Other words: n-1 = 2^s*d is split by shifting one bit per cycle, then
// 2^d mod n is built left to right over all 11 exponent bits: a square per
// bit plus a doubling folded into the same step, then s more squares.
// Every square runs through the bit-serial modular multiplier, issued from
// a MUL state and retired from a WAIT state; a nontrivial root of one
// ends the test early. One word is in flight at a time.
// Reset (rst, synchronous) returns to idle and drops done; a word in
// flight is lost.
module miller_rabin_base2_prime_test
  import mrb2_pkg::*;
#(
  parameter int CANDIDATE_LIMIT = CANDIDATE_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [CW-1:0] candidate,
  output logic          done,
  output logic [VW-1:0] verdict
);

  localparam logic [CW-1:0] LIMIT_V = CW'(CANDIDATE_LIMIT);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DECOMP   = 3'd1;
  localparam logic [2:0] ST_EXP_MUL  = 3'd2;
  localparam logic [2:0] ST_EXP_WAIT = 3'd3;
  localparam logic [2:0] ST_SQ_MUL   = 3'd4;
  localparam logic [2:0] ST_SQ_WAIT  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] n;        // modulus
  logic [CW-1:0] nm1;      // n - 1
  logic [CW-1:0] d;        // odd part, later shifted out MSB first
  logic [SW-1:0] s_cnt;    // remaining squarings
  logic [SW-1:0] bit_cnt;  // exponent bits left
  logic [CW-1:0] x;

  logic          accept;
  logic          reject;
  logic          mm_start;
  logic          mm_done;
  logic [CW-1:0] mm_prod;
  logic          root_bad;  // nontrivial square root of one

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign reject   = (candidate <= TWO) || (candidate >= LIMIT_V) || !candidate[0];
  assign mm_start = (state == ST_EXP_MUL) || (state == ST_SQ_MUL);
  assign root_bad = (mm_prod == ONE) && (x != ONE) && (x != nm1);

  mrb2_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (x),
    .b       (x),
    .m       (n),
    .done    (mm_done),
    .product (mm_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (reject) begin
              verdict <= VERDICT_REJECTED;
              done    <= 1'b1;
            end else begin
              n     <= candidate;
              nm1   <= candidate - ONE;
              d     <= candidate - ONE;
              s_cnt <= '0;
              state <= ST_DECOMP;
            end
          end
        end
        ST_DECOMP: begin
          // strip trailing zeros of n-1
          if (d[0]) begin
            bit_cnt <= SW'(CW);
            x       <= ONE;
            state   <= ST_EXP_MUL;
          end else begin
            d     <= {1'b0, d[CW-1:1]};
            s_cnt <= s_cnt + SW'(1);
          end
        end
        ST_EXP_MUL: begin
          state <= ST_EXP_WAIT;
        end
        ST_EXP_WAIT: begin
          if (mm_done) begin
            // square, then double when the exponent bit is set
            x       <= d[CW-1] ? mod_dbl(mm_prod, n) : mm_prod;
            d       <= {d[CW-2:0], 1'b0};
            bit_cnt <= bit_cnt - SW'(1);
            state   <= (bit_cnt == SW'(1)) ? ST_SQ_MUL : ST_EXP_MUL;
          end
        end
        ST_SQ_MUL: begin
          state <= ST_SQ_WAIT;
        end
        ST_SQ_WAIT: begin
          if (mm_done) begin
            if (root_bad) begin
              verdict <= VERDICT_COMPOSITE;
              done    <= 1'b1;
              state   <= ST_IDLE;
            end else if (s_cnt == SW'(1)) begin
              verdict <= (mm_prod == ONE) ? VERDICT_PRIME : VERDICT_COMPOSITE;
              done    <= 1'b1;
              state   <= ST_IDLE;
            end else begin
              x     <= mm_prod;
              s_cnt <= s_cnt - SW'(1);
              state <= ST_SQ_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_reject_fast: assert property (@(posedge clk) disable iff (rst)
    accept && reject |=> done && (verdict == VERDICT_REJECTED))
    else $error("rejected word not answered next cycle");
  a_mul_in_test: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == ST_EXP_WAIT) || (state == ST_SQ_WAIT))
    else $error("multiplier finished outside a wait state");
  a_tested_from_busy: assert property (@(posedge clk) disable iff (rst)
    done && (verdict != VERDICT_REJECTED) |-> $past(busy) && !busy)
    else $error("verdict without a test in flight");
  a_squares_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ_MUL) |-> (s_cnt != '0))
    else $error("squaring with no count left");
`endif

endmodule

`default_nettype wire

@@ sv/mrb2_modmul.sv @@
`default_nettype none

// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
module mrb2_modmul
  import mrb2_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [CW-1:0] a,
  input  logic [CW-1:0] b,
  input  logic [CW-1:0] m,
  output logic          done,
  output logic [CW-1:0] product
);

  logic          running;
  logic [SW-1:0] cnt;
  logic [CW-1:0] mplr;
  logic [CW-1:0] mcand;
  logic [CW-1:0] modulus;
  logic [CW-1:0] acc;
  logic [CW-1:0] acc_dbl;
  logic [CW-1:0] acc_next;

  always_comb begin
    acc_dbl  = mod_dbl(acc, modulus);
    acc_next = mplr[CW-1] ? mod_add(acc_dbl, mcand, modulus) : acc_dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= SW'(CW);
        mcand   <= a;
        mplr    <= b;
        modulus <= m;
        acc     <= '0;
      end else if (running) begin
        acc  <= acc_next;
        mplr <= {mplr[CW-2:0], 1'b0};
        cnt  <= cnt - SW'(1);
        if (cnt == SW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

`ifndef NO_ASSERTIONS
  a_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> product < modulus)
    else $error("product not reduced");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !running)
    else $error("start while running");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !running)
    else $error("done while running");
`endif

endmodule

`default_nettype wire
